/* hw/rtl/cau_pkg.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Opcodes, channel payloads and the pipeline work record that the stages share.
// ----------------------------------------------------------------------------
package cau_pkg;

  // Opcodes of the request channel.
  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MOD  = 4'd4,
    OP_CONJ = 4'd5,
    OP_ABS  = 4'd6,
    OP_EQ   = 4'd7,
    OP_NE   = 4'd8,
    OP_LT   = 4'd9,
    OP_GT   = 4'd10,
    OP_LE   = 4'd11,
    OP_GE   = 4'd12,
    OP_RE   = 4'd13,
    OP_IM   = 4'd14,
    OP_PAIR = 4'd15
  } cau_op_t;

  // Saturation limits of a 32-bit signed part.
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // Number of quotient and root bits, one per iteration stage.
  localparam int STEPS = 32;

  // Request payload.
  typedef struct packed {
    cau_op_t            req_type;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } cmd_t;

  // Result payload.
  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic               div_by_zero;
    logic               overflow;
  } res_t;

  // Per-item control and precomputed results that ride along the pipeline.
  typedef struct packed {
    cau_op_t            op;
    logic signed [31:0] simp_re;
    logic signed [31:0] simp_im;
    logic               ovf;
    logic               dz;
    logic               neg_re;
    logic               neg_im;
    logic               big_re;
    logic               big_im;
  } side_t;

  // One restoring-division lane: partial remainder, dividend bits, quotient.
  typedef struct packed {
    logic [63:0] r;
    logic [31:0] d;
    logic [31:0] q;
  } lane_t;

  // Digit-by-digit square root state.
  typedef struct packed {
    logic [33:0] rem;
    logic [63:0] opnd;
    logic [31:0] root;
  } root_t;

  // Everything one iteration stage holds for an item.
  typedef struct packed {
    side_t       side;
    lane_t       lane_re;
    lane_t       lane_im;
    logic [63:0] c;
    root_t       sq;
  } work_t;

endpackage

/* hw/rtl/complex_arith_unit.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined signed fixed-point complex ALU: add, sub, mul, div, mod, conj,
// magnitude, comparisons, part selection and pair construction.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (cmd_valid, cmd_ready, cmd) carries an opcode and two
//   complex operands; the result channel (res_valid, res_ready, res) returns
//   one complex result with div_by_zero and overflow flags per request.
//   A transfer happens on a rising edge where valid and ready are both high.
//   Every request takes the same path: three front stages (products, sums,
//   divider setup), 32 iteration stages that each resolve one quotient bit of
//   two division lanes and one square-root bit, and an output register.
//   One request per cycle is taken, sustained, whatever the opcode, while
//   the output is drained; results leave in request order.
//   When the receiver stalls, each stage holds its item and empty stages keep
//   filling, so requests are still taken until every stage is occupied.
//   A synchronous reset clears all stage valid bits; no request is lost or
//   repeated across a stall. There is no configuration.
// ----------------------------------------------------------------------------
module complex_arith_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cau_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output cau_pkg::res_t res
);
  import cau_pkg::*;

  logic  st_valid [STEPS+1];
  logic  st_ready [STEPS+1];
  work_t st_data  [STEPS+1];

  // Multiply, sum and divider setup.
  cau_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cmd_valid),
    .up_ready (cmd_ready),
    .up_data  (cmd),
    .dn_valid (st_valid[0]),
    .dn_ready (st_ready[0]),
    .dn_data  (st_data[0])
  );

  // One stage per quotient and root bit.
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    cau_iter u_iter (
      .clk      (clk),
      .rst      (rst),
      .up_valid (st_valid[i]),
      .up_ready (st_ready[i]),
      .up_data  (st_data[i]),
      .dn_valid (st_valid[i+1]),
      .dn_ready (st_ready[i+1]),
      .dn_data  (st_data[i+1])
    );
  end

  // Result selection and output register.
  cau_back u_back (
    .clk      (clk),
    .rst      (rst),
    .up_valid (st_valid[STEPS]),
    .up_ready (st_ready[STEPS]),
    .up_data  (st_data[STEPS]),
    .dn_valid (res_valid),
    .dn_ready (res_ready),
    .dn_data  (res)
  );

endmodule

/* hw/rtl/cau_front.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Three register stages: products, sums and simple results, divider setup.
// ----------------------------------------------------------------------------
module cau_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  cau_pkg::cmd_t  up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output cau_pkg::work_t dn_data
);
  import cau_pkg::*;

  localparam logic [32:0] ONE = 33'(1) << FRAC_BITS;

  logic               p_en, s_en, d_en;

  // Product stage signals.
  logic signed [31:0] in_ar, in_ai, in_br, in_bi, mx, my;
  logic signed [63:0] prod_next [6];
  logic               p_valid;
  cau_op_t            p_op;
  logic signed [31:0] p_ar, p_ai, p_br, p_bi;
  logic signed [63:0] p_prod [6];

  // Sum stage signals.
  logic signed [64:0] sum_re_next, sum_im_next;
  logic        [63:0] csq_next;
  logic signed [32:0] t_re, t_im;
  logic               ov_re, ov_im, dz_next;
  logic signed [31:0] simp_re_next, simp_im_next;
  logic               s_valid;
  cau_op_t            s_op;
  logic signed [64:0] s_sum_re, s_sum_im;
  logic        [63:0] s_csq;
  logic signed [31:0] s_simp_re, s_simp_im, s_ar, s_ai, s_br;
  logic               s_ovf, s_dz;

  // Setup stage signals.
  logic [63:0]        mag_re, mag_im, r0_re, r0_im;
  logic signed [64:0] fl_re, fl_im;
  logic               ok_re, ok_im;
  logic signed [31:0] mul_re, mul_im;
  logic [31:0]        abs_ar, abs_ai, abs_br;
  work_t              work_next;

  // Each stage moves when its successor is empty or moving.
  assign d_en     = !dn_valid || dn_ready;
  assign s_en     = !s_valid || d_en;
  assign p_en     = !p_valid || s_en;
  assign up_ready = p_en;

  // Operand products; the magnitude opcode squares the first operand instead.
  always_comb begin
    in_ar = up_data.a_real;
    in_ai = up_data.a_imag;
    in_br = up_data.b_real;
    in_bi = up_data.b_imag;
    mx    = (up_data.req_type == OP_ABS) ? in_ar : in_br;
    my    = (up_data.req_type == OP_ABS) ? in_ai : in_bi;
    prod_next[0] = in_ar * in_br;
    prod_next[1] = in_ai * in_bi;
    prod_next[2] = in_ar * in_bi;
    prod_next[3] = in_ai * in_br;
    prod_next[4] = mx * mx;
    prod_next[5] = my * my;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_en) begin
      p_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_en && up_valid) begin
      p_op   <= up_data.req_type;
      p_ar   <= in_ar;
      p_ai   <= in_ai;
      p_br   <= in_br;
      p_bi   <= in_bi;
      p_prod <= prod_next;
    end
  end

  // Sums of products for multiply, divide and magnitude.
  always_comb begin
    if (p_op == OP_MUL) begin
      sum_re_next = p_prod[0] - p_prod[1];
      sum_im_next = p_prod[2] + p_prod[3];
    end else begin
      sum_re_next = p_prod[0] + p_prod[1];
      sum_im_next = p_prod[3] - p_prod[2];
    end
    csq_next = $unsigned(p_prod[4]) + $unsigned(p_prod[5]);
  end

  // Results of the opcodes that need no multiplier or divider.
  always_comb begin
    t_re = '0;
    t_im = '0;
    case (p_op)
      OP_ADD: begin
        t_re = {p_ar[31], p_ar} + {p_br[31], p_br};
        t_im = {p_ai[31], p_ai} + {p_bi[31], p_bi};
      end
      OP_SUB: begin
        t_re = {p_ar[31], p_ar} - {p_br[31], p_br};
        t_im = {p_ai[31], p_ai} - {p_bi[31], p_bi};
      end
      OP_CONJ: begin
        t_re = {p_ar[31], p_ar};
        t_im = 33'd0 - {p_ai[31], p_ai};
      end
      OP_EQ: begin
        t_re = (p_ar == p_br) ? ONE : '0;
        t_im = (p_ai == p_bi) ? ONE : '0;
      end
      OP_NE: begin
        t_re = (p_ar != p_br) ? ONE : '0;
        t_im = (p_ai != p_bi) ? ONE : '0;
      end
      OP_LT: begin
        t_re = (p_ar < p_br) ? ONE : '0;
        t_im = (p_ai < p_bi) ? ONE : '0;
      end
      OP_GT: begin
        t_re = (p_ar > p_br) ? ONE : '0;
        t_im = (p_ai > p_bi) ? ONE : '0;
      end
      OP_LE: begin
        t_re = (p_ar <= p_br) ? ONE : '0;
        t_im = (p_ai <= p_bi) ? ONE : '0;
      end
      OP_GE: begin
        t_re = (p_ar >= p_br) ? ONE : '0;
        t_im = (p_ai >= p_bi) ? ONE : '0;
      end
      OP_RE: begin
        t_re = {p_ar[31], p_ar};
      end
      OP_IM: begin
        t_re = {p_ai[31], p_ai};
      end
      OP_PAIR: begin
        t_re = {p_ar[31], p_ar};
        t_im = {p_br[31], p_br};
      end
      default: begin
        t_re = '0;
        t_im = '0;
      end
    endcase
    ov_re        = t_re[32] ^ t_re[31];
    ov_im        = t_im[32] ^ t_im[31];
    simp_re_next = ov_re ? (t_re[32] ? SAT_MIN : SAT_MAX) : t_re[31:0];
    simp_im_next = ov_im ? (t_im[32] ? SAT_MIN : SAT_MAX) : t_im[31:0];
    dz_next      = ((p_op == OP_DIV) && (p_br == '0) && (p_bi == '0)) ||
                   ((p_op == OP_MOD) && (p_br == '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_en) begin
      s_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_en && p_valid) begin
      s_op      <= p_op;
      s_sum_re  <= sum_re_next;
      s_sum_im  <= sum_im_next;
      s_csq     <= csq_next;
      s_simp_re <= simp_re_next;
      s_simp_im <= simp_im_next;
      s_ovf     <= ov_re | ov_im;
      s_dz      <= dz_next;
      s_ar      <= p_ar;
      s_ai      <= p_ai;
      s_br      <= p_br;
    end
  end

  // Multiply rounding and divider setup. A quotient that would need more
  // than 32 bits is caught here by one compare against the divisor.
  always_comb begin
    mag_re = 64'(s_sum_re[64] ? -s_sum_re : s_sum_re);
    mag_im = 64'(s_sum_im[64] ? -s_sum_im : s_sum_im);
    r0_re  = mag_re >> (32 - FRAC_BITS);
    r0_im  = mag_im >> (32 - FRAC_BITS);
    fl_re  = s_sum_re >>> FRAC_BITS;
    fl_im  = s_sum_im >>> FRAC_BITS;
    ok_re  = (fl_re[64:31] == '0) || (fl_re[64:31] == '1);
    ok_im  = (fl_im[64:31] == '0) || (fl_im[64:31] == '1);
    mul_re = ok_re ? fl_re[31:0] : (fl_re[64] ? SAT_MIN : SAT_MAX);
    mul_im = ok_im ? fl_im[31:0] : (fl_im[64] ? SAT_MIN : SAT_MAX);
    abs_ar = s_ar[31] ? 32'(-s_ar) : s_ar;
    abs_ai = s_ai[31] ? 32'(-s_ai) : s_ai;
    abs_br = s_br[31] ? 32'(-s_br) : s_br;

    work_next.side.op      = s_op;
    work_next.side.simp_re = (s_op == OP_MUL) ? mul_re : s_simp_re;
    work_next.side.simp_im = (s_op == OP_MUL) ? mul_im : s_simp_im;
    work_next.side.ovf     = (s_op == OP_MUL) ? (!ok_re || !ok_im) : s_ovf;
    work_next.side.dz      = s_dz;
    work_next.sq.rem       = '0;
    work_next.sq.opnd      = s_csq;
    work_next.sq.root      = '0;
    work_next.lane_re.q    = '0;
    work_next.lane_im.q    = '0;

    if (s_op == OP_MOD) begin
      work_next.side.neg_re = s_ar[31];
      work_next.side.neg_im = s_ai[31];
      work_next.side.big_re = 1'b0;
      work_next.side.big_im = 1'b0;
      work_next.lane_re.r   = '0;
      work_next.lane_im.r   = '0;
      work_next.lane_re.d   = abs_ar;
      work_next.lane_im.d   = abs_ai;
      work_next.c           = {32'd0, abs_br};
    end else begin
      work_next.side.neg_re = s_sum_re[64];
      work_next.side.neg_im = s_sum_im[64];
      work_next.side.big_re = (r0_re >= s_csq);
      work_next.side.big_im = (r0_im >= s_csq);
      work_next.lane_re.r   = r0_re;
      work_next.lane_im.r   = r0_im;
      work_next.lane_re.d   = 32'(mag_re << FRAC_BITS);
      work_next.lane_im.d   = 32'(mag_im << FRAC_BITS);
      work_next.c           = s_csq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (d_en) begin
      dn_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_en && s_valid) begin
      dn_data <= work_next;
    end
  end

endmodule

/* hw/rtl/cau_iter.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit iteration stage
// One quotient bit for each of two division lanes and one root bit per stage.
// ----------------------------------------------------------------------------
module cau_iter (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  cau_pkg::work_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output cau_pkg::work_t dn_data
);
  import cau_pkg::*;

  logic  en;
  work_t work_next;

  // Restoring division step: shift in one dividend bit, subtract if it fits.
  function automatic lane_t div_step(input lane_t l, input logic [63:0] c);
    logic [64:0] rsh;
    lane_t       o;
    rsh = {l.r, l.d[31]};
    o   = l;
    if (rsh >= {1'b0, c}) begin
      o.r = 64'(rsh - {1'b0, c});
      o.q = {l.q[30:0], 1'b1};
    end else begin
      o.r = rsh[63:0];
      o.q = {l.q[30:0], 1'b0};
    end
    o.d = {l.d[30:0], 1'b0};
    return o;
  endfunction

  // Square root step: bring down two operand bits, try root*4+1.
  function automatic root_t sqrt_step(input root_t s);
    logic [35:0] rsh;
    logic [35:0] trial;
    root_t       o;
    rsh   = {s.rem, s.opnd[63:62]};
    trial = {2'b00, s.root, 2'b01};
    o     = s;
    if (rsh >= trial) begin
      o.rem  = 34'(rsh - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = rsh[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    o.opnd = {s.opnd[61:0], 2'b00};
    return o;
  endfunction

  always_comb begin
    work_next         = up_data;
    work_next.lane_re = div_step(up_data.lane_re, up_data.c);
    work_next.lane_im = div_step(up_data.lane_im, up_data.c);
    work_next.sq      = sqrt_step(up_data.sq);
  end

  assign en       = !dn_valid || dn_ready;
  assign up_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      dn_data <= work_next;
    end
  end

endmodule

/* hw/rtl/cau_back.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Picks the final result per opcode, saturates it and holds it for transfer.
// ----------------------------------------------------------------------------
module cau_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  cau_pkg::work_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output cau_pkg::res_t  dn_data
);
  import cau_pkg::*;

  logic        en;
  logic [32:0] qr_re, qr_im;
  res_t        res_next;

  // Sign, overflow and saturation of one quotient; returns {overflow, value}.
  function automatic logic [32:0] quo_part(input logic neg, input logic big,
                                           input logic [31:0] q);
    logic [32:0] o;
    if (big) begin
      o = {1'b1, (neg ? SAT_MIN : SAT_MAX)};
    end else if (!neg) begin
      o = q[31] ? {1'b1, SAT_MAX} : {1'b0, q};
    end else if (q > 32'h8000_0000) begin
      o = {1'b1, SAT_MIN};
    end else begin
      o = {1'b0, 32'd0 - q};
    end
    return o;
  endfunction

  always_comb begin
    qr_re = quo_part(up_data.side.neg_re, up_data.side.big_re, up_data.lane_re.q);
    qr_im = quo_part(up_data.side.neg_im, up_data.side.big_im, up_data.lane_im.q);
    res_next.res_real    = up_data.side.simp_re;
    res_next.res_imag    = up_data.side.simp_im;
    res_next.div_by_zero = 1'b0;
    res_next.overflow    = up_data.side.ovf;
    case (up_data.side.op)
      OP_DIV: begin
        if (up_data.side.dz) begin
          res_next.res_real    = '0;
          res_next.res_imag    = '0;
          res_next.div_by_zero = 1'b1;
          res_next.overflow    = 1'b0;
        end else begin
          res_next.res_real = qr_re[31:0];
          res_next.res_imag = qr_im[31:0];
          res_next.overflow = qr_re[32] | qr_im[32];
        end
      end
      OP_MOD: begin
        // The remainder takes the sign of the dividend.
        res_next.overflow = 1'b0;
        if (up_data.side.dz) begin
          res_next.res_real    = '0;
          res_next.res_imag    = '0;
          res_next.div_by_zero = 1'b1;
        end else begin
          res_next.res_real = up_data.side.neg_re ? 32'd0 - up_data.lane_re.r[31:0]
                                                  : up_data.lane_re.r[31:0];
          res_next.res_imag = up_data.side.neg_im ? 32'd0 - up_data.lane_im.r[31:0]
                                                  : up_data.lane_im.r[31:0];
        end
      end
      OP_ABS: begin
        res_next.res_imag = '0;
        res_next.overflow = up_data.sq.root[31];
        res_next.res_real = up_data.sq.root[31] ? SAT_MAX : up_data.sq.root;
      end
      default: begin
        res_next.res_real = up_data.side.simp_re;
      end
    endcase
  end

  assign en       = !dn_valid || dn_ready;
  assign up_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      dn_data <= res_next;
    end
  end

  // A zero divisor on divide always returns zero in both parts.
  a_div_zero_result: assert property (@(posedge clk) disable iff (rst)
    (up_valid && up_ready && up_data.side.op == OP_DIV && up_data.side.dz) |=>
    (dn_data.res_real == '0 && dn_data.res_imag == '0 && dn_data.div_by_zero))
    else $error("divide by zero did not return zero");

  // Magnitude has no imaginary part and never flags a zero divisor.
  a_abs_imag_zero: assert property (@(posedge clk) disable iff (rst)
    (up_valid && up_ready && up_data.side.op == OP_ABS) |=>
    (dn_data.res_imag == '0 && !dn_data.div_by_zero))
    else $error("magnitude result has nonzero imaginary part");

  // A zero divisor and a saturation never come together.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    dn_valid |-> !(dn_data.div_by_zero && dn_data.overflow))
    else $error("div_by_zero and overflow both set");

  // Only divide and remainder can flag a zero divisor.
  a_dz_opcode: assert property (@(posedge clk) disable iff (rst)
    (up_valid && up_data.side.dz) |->
    (up_data.side.op == OP_DIV || up_data.side.op == OP_MOD))
    else $error("zero divisor flagged on a non-dividing opcode");

endmodule

/* dv/tb_complex_arith_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives opcodes and operands through the request channel with random gaps,
// predicts every result in fixed point, and compares each result transfer
// field by field in order. One phase stalls the receiver long enough to fill
// the pipeline and stall the request channel.
// ----------------------------------------------------------------------------
module tb_complex_arith_unit;
  import cau_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = 35;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic res_valid;
  logic res_ready;
  res_t res;

  res_t expected_q[$];
  int errors;
  bit hold_sink;

  complex_arith_unit #(.FRAC_BITS(FB)) uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Saturate a wide value to a 32-bit part.
  function automatic logic signed [31:0] sat(input logic signed [129:0] v, inout bit ov);
    if (v > 130'sd2147483647) begin
      ov = 1;
      return SAT_MAX;
    end
    if (v < -130'sd2147483648) begin
      ov = 1;
      return SAT_MIN;
    end
    return v[31:0];
  endfunction

  // Floor division of a wide value by 2^FB.
  function automatic logic signed [129:0] floor_shift(input logic signed [129:0] v);
    return v >>> FB;
  endfunction

  // Truncating division of a wide numerator (scaled by 2^FB) by c.
  function automatic logic signed [129:0] trunc_div(input logic signed [129:0] n,
                                                    input logic signed [129:0] c);
    logic signed [129:0] m;
    logic signed [129:0] q;
    m = (n < 0) ? -n : n;
    q = (m <<< FB) / c;
    return (n < 0) ? -q : q;
  endfunction

  // Integer square root by bisection on a 65-bit value.
  function automatic logic [63:0] int_sqrt(input logic [64:0] s);
    logic [64:0] lo;
    logic [64:0] hi;
    logic [64:0] mid;
    lo = 0;
    hi = 65'h1_0000_0000;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= s) lo = mid;
      else hi = mid;
    end
    return lo[63:0];
  endfunction

  // Compute the expected result of one request.
  function automatic res_t complex_result(input cmd_t c);
    res_t r;
    bit ov;
    logic signed [129:0] ar, ai, br, bi, den;
    logic signed [31:0] one;
    ar = c.a_real;
    ai = c.a_imag;
    br = c.b_real;
    bi = c.b_imag;
    one = 32'sd1 <<< FB;
    ov = 0;
    r = '0;
    case (c.req_type)
      OP_ADD: begin
        r.res_real = sat(ar + br, ov);
        r.res_imag = sat(ai + bi, ov);
      end
      OP_SUB: begin
        r.res_real = sat(ar - br, ov);
        r.res_imag = sat(ai - bi, ov);
      end
      OP_MUL: begin
        r.res_real = sat(floor_shift(ar * br - ai * bi), ov);
        r.res_imag = sat(floor_shift(ar * bi + ai * br), ov);
      end
      OP_DIV: begin
        if (br == 0 && bi == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          den = br * br + bi * bi;
          r.res_real = sat(trunc_div(ar * br + ai * bi, den), ov);
          r.res_imag = sat(trunc_div(ai * br - ar * bi, den), ov);
        end
      end
      OP_MOD: begin
        if (br == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          r.res_real = 32'(ar % br);
          r.res_imag = 32'(ai % br);
        end
      end
      OP_CONJ: begin
        r.res_real = c.a_real;
        r.res_imag = sat(-ai, ov);
      end
      OP_ABS: r.res_real = sat($signed({66'd0, int_sqrt(65'(ar * ar + ai * ai))}), ov);
      OP_EQ: begin
        r.res_real = (ar == br) ? one : 0;
        r.res_imag = (ai == bi) ? one : 0;
      end
      OP_NE: begin
        r.res_real = (ar != br) ? one : 0;
        r.res_imag = (ai != bi) ? one : 0;
      end
      OP_LT: begin
        r.res_real = (ar < br) ? one : 0;
        r.res_imag = (ai < bi) ? one : 0;
      end
      OP_GT: begin
        r.res_real = (ar > br) ? one : 0;
        r.res_imag = (ai > bi) ? one : 0;
      end
      OP_LE: begin
        r.res_real = (ar <= br) ? one : 0;
        r.res_imag = (ai <= bi) ? one : 0;
      end
      OP_GE: begin
        r.res_real = (ar >= br) ? one : 0;
        r.res_imag = (ai >= bi) ? one : 0;
      end
      OP_RE: r.res_real = c.a_real;
      OP_IM: r.res_real = c.a_imag;
      default: begin
        r.res_real = c.a_real;
        r.res_imag = c.b_real;
      end
    endcase
    r.overflow = ov;
    return r;
  endfunction

  // Random gap length: mostly short, sometimes long.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Random operand part, biased toward edge values.
  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'(int'($urandom_range(0, 8)) - 4) <<< FB;
      4: return 32'(int'($urandom_range(0, 2000)) - 1000);
      5: return $urandom & 32'h000F_FFFF | ({32{$urandom_range(0, 1) == 1}} & 32'hFFF0_0000);
      default: return $urandom;
    endcase
  endfunction

  // Send one request and record its expected result on transfer. Valid stays
  // high between back-to-back transfers and drops only for a gap.
  task automatic send_cmd(input cmd_t c, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      cmd_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    expected_q.push_back(complex_result(c));
    @(negedge clk);
  endtask

  function automatic cmd_t make_cmd(input cau_op_t op, input logic [31:0] ar,
                                    input logic [31:0] ai, input logic [31:0] br,
                                    input logic [31:0] bi);
    cmd_t c;
    c.req_type = op;
    c.a_real = ar;
    c.a_imag = ai;
    c.b_real = br;
    c.b_imag = bi;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c = make_cmd(cau_op_t'($urandom_range(0, 15)), rand_part(), rand_part(),
                 rand_part(), rand_part());
    // Keep zero divisors present but not dominant.
    if ($urandom_range(0, 15) == 0) c.b_real = 0;
    if ($urandom_range(0, 15) == 0) c.b_imag = 0;
    return c;
  endfunction

  // Every opcode, many at the field extremes, plus zero divisors and saturation.
  task automatic test_directed();
    send_cmd(make_cmd(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF), 0);
    send_cmd(make_cmd(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF), 0);
    send_cmd(make_cmd(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF), 0);
    send_cmd(make_cmd(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0), 0);
    send_cmd(make_cmd(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0), 0);
    send_cmd(make_cmd(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0), 0);
    send_cmd(make_cmd(OP_DIV, 32'h0003_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000), 0);
    send_cmd(make_cmd(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0);
    send_cmd(make_cmd(OP_MOD, 32'h0007_0000, 32'hFFF9_0000, 32'h0, 32'h5), 0);
    send_cmd(make_cmd(OP_MOD, 32'h8000_0000, 32'hFFF9_1234, 32'hFFFF_FFFF, 32'h0), 0);
    send_cmd(make_cmd(OP_MOD, 32'h0007_0000, 32'hFFF9_0000, 32'h0003_0000, 32'h0), 0);
    send_cmd(make_cmd(OP_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0), 0);
    send_cmd(make_cmd(OP_CONJ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0), 0);
    send_cmd(make_cmd(OP_ABS, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0), 0);
    send_cmd(make_cmd(OP_ABS, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0), 0);
    send_cmd(make_cmd(OP_EQ, 32'h5, 32'h6, 32'h5, 32'h7), 0);
    send_cmd(make_cmd(OP_NE, 32'h5, 32'h6, 32'h5, 32'h7), 0);
    send_cmd(make_cmd(OP_LT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000), 0);
    send_cmd(make_cmd(OP_GT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000), 0);
    send_cmd(make_cmd(OP_LE, 32'h3, 32'h4, 32'h3, 32'h3), 0);
    send_cmd(make_cmd(OP_GE, 32'h3, 32'h4, 32'h3, 32'h5), 0);
    send_cmd(make_cmd(OP_RE, 32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_FFFF, 32'h1), 0);
    send_cmd(make_cmd(OP_IM, 32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_FFFF, 32'h1), 0);
    send_cmd(make_cmd(OP_PAIR, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF), 0);
  endtask

  // Random requests with gaps on both channels.
  task automatic test_random(input int count);
    repeat (count) send_cmd(rand_cmd(), $urandom_range(0, 3) != 0);
  endtask

  // Back-to-back requests while the receiver holds off, filling the pipeline.
  task automatic test_backpressure();
    hold_sink = 1'b1;
    fork
      begin
        repeat (120) @(posedge clk);
        hold_sink = 1'b0;
      end
      repeat (80) send_cmd(rand_cmd(), 0);
    join
  endtask

  // Receiver ready with random gaps, or held off during the stall phase.
  initial begin
    int g;
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        res_ready <= 1'b0;
      end else if (!res_ready) begin
        res_ready <= 1'b1;
      end else begin
        g = gap_len();
        if (g > 0) begin
          res_ready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin
    res_t exp_res;
    if (!rst && res_valid && res_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res);
        errors++;
      end else begin
        exp_res = expected_q.pop_front();
        if (res.res_real !== exp_res.res_real) begin
          $display("%0t: res_real expected %h actual %h", $time, exp_res.res_real,
                   res.res_real);
          errors++;
        end
        if (res.res_imag !== exp_res.res_imag) begin
          $display("%0t: res_imag expected %h actual %h", $time, exp_res.res_imag,
                   res.res_imag);
          errors++;
        end
        if (res.div_by_zero !== exp_res.div_by_zero) begin
          $display("%0t: div_by_zero expected %b actual %b", $time, exp_res.div_by_zero,
                   res.div_by_zero);
          errors++;
        end
        if (res.overflow !== exp_res.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time, exp_res.overflow,
                   res.overflow);
          errors++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int waited;
    errors = 0;
    hold_sink = 1'b0;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(300);
    test_backpressure();
    test_random(250);
    cmd_valid <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cau_pkg.sv
hw/rtl/cau_front.sv
hw/rtl/cau_iter.sv
hw/rtl/cau_back.sv
hw/rtl/complex_arith_unit.sv
dv/tb_complex_arith_unit.sv
